// ----- rtl/shuffled_park_miller_rng_assert.svh -----
// ----------------------------------------------------------------------------
// shuffled_park_miller_rng_assert.svh
// assertion macros used by the checker file of the generator
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_PARK_MILLER_RNG_ASSERT_SVH
`define SHUFFLED_PARK_MILLER_RNG_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spmr assertion failed");

// next-cycle implication, disabled during reset
`define SPMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmr assertion failed");

`endif

// ----- rtl/spmr_pkg.sv -----
// ----------------------------------------------------------------------------
// spmr_pkg
// constants and types of the shuffled minimal standard generator
// ----------------------------------------------------------------------------
package spmr_pkg;

    localparam int VALUE_W = 31;
    localparam int MUL_W   = 15;
    localparam int PROD_W  = VALUE_W + MUL_W;

    typedef logic [VALUE_W-1:0] t_value;

    // lehmer multiplier and prime modulus 2^31-1
    localparam logic [MUL_W-1:0]   LEHMER_MUL     = 15'd16807;
    localparam logic [VALUE_W-1:0] LEHMER_MOD     = 31'h7FFF_FFFF;
    // float fraction would round past 1 - 1.2e-7 from here up
    localparam logic [VALUE_W-1:0] NEAR_ONE_LIMIT = 31'd2147483390;

endpackage

// ----- rtl/shuffled_park_miller_rng.sv -----
// ----------------------------------------------------------------------------
// shuffled_park_miller_rng
// minimal standard lehmer generator behind a bays-durham shuffle table
// ----------------------------------------------------------------------------
//   slave stream: one transaction per draw; s_axis_tdata[0] = reseed.
//     reseed = 1 seeds from the seed register (0 acts as 1), discards one
//     draw and then draws; reseed = 0 just draws.
//   master stream: one transaction per input; tdata[30:0] = value
//     (fraction = value / (2^31-1)), tuser[0] = near_one.
//   config: i_cfg_wr_en writes i_cfg_wr_data into the seed register.
// flow: a plain draw runs check, multiply, reduce, remainder, divide, read
//   and swap before tvalid, and the next request is taken only after the swap;
//   each seeding runs its lehmer steps through the shared multiply-reduce
//   unit and fills the table; a reseed item adds one seeding and one
//   discarded draw to a plain draw. a depth that is not a power of two
//   adds index correction steps to a draw. tready is high only
//   while idle. a seed of 2^31-1 collapses and costs one more seeding.
// reset: seed register becomes 1, generator is unseeded, so the first draw
//   seeds with 1. a stalled result holds the next draw at its table swap;
//   tready stays low meanwhile, so no further item is accepted.
// ----------------------------------------------------------------------------
module shuffled_park_miller_rng #(
    parameter int SHUFFLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register write
    input  logic        i_cfg_wr_en,
    input  logic [30:0] i_cfg_wr_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] reseed, [7:1] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] value, [31] zero
    output logic [0:0]  m_axis_tuser    // [0] near_one
);

    localparam int VW    = spmr_pkg::VALUE_W;
    localparam int IDX_W = $clog2(SHUFFLE_DEPTH);
    localparam int QW    = IDX_W + 1;
    localparam int HI_W  = VW - 16;
    localparam int CNT_W = $clog2(SHUFFLE_DEPTH + 8);

    localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'(SHUFFLE_DEPTH + 7);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SHUFFLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_MAX   = IDX_W'(SHUFFLE_DEPTH - 1);
    localparam logic [QW-1:0]    QUO_MAX   = QW'(SHUFFLE_DEPTH - 1);
    localparam longint           TABLE_DIV = 1 + (2147483646 / SHUFFLE_DEPTH);
    // table index divisor and its scaled reciprocal floor(2^31 / divisor)
    localparam logic [VW-1:0]    DIV_STEP  = VW'(TABLE_DIV);
    localparam logic [QW-1:0]    DIV_RECIP = QW'((longint'(1) << 31) / TABLE_DIV);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_RED   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_SWAP  = 3'd6;
    localparam logic [2:0] ST_REM   = 3'd7;

    logic [2:0]       r_state, n_state;
    spmr_pkg::t_value r_seed;
    spmr_pkg::t_value r_lehmer, n_lehmer;
    spmr_pkg::t_value r_last, n_last;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_seeding, n_seeding;
    logic             r_discard, n_discard;
    spmr_pkg::t_value r_rem, n_rem;
    logic [QW-1:0]    r_quo, n_quo;
    logic             r_out_valid;
    spmr_pkg::t_value r_out_value;
    logic             r_out_near;

    logic               lehmer_load;
    spmr_pkg::t_value   lehmer_next;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_wa;
    spmr_pkg::t_value   ram_wd;
    logic               ram_re;
    spmr_pkg::t_value   ram_rd;
    logic [IDX_W-1:0]   tbl_idx;
    logic [HI_W+QW-1:0] est_prod;
    logic [QW-1:0]      quo_est;
    logic [QW+VW-1:0]   quo_prod;
    logic               rem_ge;
    logic               swap_go;
    logic               out_load;

    // shared lehmer step unit
    spmr_lehmer_unit u_lehmer (
        .i_clk  (i_clk),
        .i_load (lehmer_load),
        .i_x    (r_lehmer),
        .o_next (lehmer_next)
    );

    // shuffle table
    spmr_ram #(
        .WIDTH (VW),
        .DEPTH (SHUFFLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (tbl_idx),
        .o_rd_data (ram_rd)
    );

    // index estimate from the top 15 bits, scaled down by 2^15;
    // never above the true index and at most two below it
    assign est_prod = (HI_W+QW)'(r_last[VW-1:16]) * (HI_W+QW)'(DIV_RECIP);
    assign quo_est  = est_prod[HI_W+QW-1:HI_W];

    // remainder of the estimate and the correction compare
    assign quo_prod = (QW+VW)'(r_quo) * (QW+VW)'(DIV_STEP);
    assign rem_ge   = (r_rem >= DIV_STEP);
    assign tbl_idx  = (r_quo > QUO_MAX) ? IDX_MAX : r_quo[IDX_W-1:0];

    // swap may finish when the draw is discarded or the output slot is free
    assign swap_go  = r_discard || !r_out_valid || m_axis_tready;
    assign out_load = (r_state == ST_SWAP) && !r_discard && swap_go;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_lehmer    = r_lehmer;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_seeding   = r_seeding;
        n_discard   = r_discard;
        n_rem       = r_rem;
        n_quo       = r_quo;
        lehmer_load = 1'b0;
        ram_we      = 1'b0;
        ram_wa      = tbl_idx;
        ram_wd      = r_lehmer;
        ram_re      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tdata[0]) begin
                        n_lehmer  = (r_seed == '0) ? VW'(1) : r_seed;
                        n_cnt     = WARM_LAST;
                        n_seeding = 1'b1;
                        n_discard = 1'b1;
                        n_state   = ST_MUL;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // unseeded generator seeds with one first
                if (r_lehmer == '0 || r_last == '0) begin
                    n_lehmer  = VW'(1);
                    n_cnt     = WARM_LAST;
                    n_seeding = 1'b1;
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                lehmer_load = 1'b1;
                n_state     = ST_RED;
            end
            ST_RED: begin
                n_lehmer = lehmer_next;
                if (r_seeding) begin
                    // warm-up; the last steps fill the table downward
                    if (r_cnt < DEPTH_CNT) begin
                        ram_we = 1'b1;
                        ram_wa = r_cnt[IDX_W-1:0];
                        ram_wd = lehmer_next;
                    end
                    if (r_cnt == '0) begin
                        n_last    = lehmer_next;
                        n_seeding = 1'b0;
                        n_state   = ST_CHECK;
                    end else begin
                        n_cnt   = r_cnt - CNT_W'(1);
                        n_state = ST_MUL;
                    end
                end else begin
                    n_quo   = quo_est;
                    n_state = ST_REM;
                end
            end
            ST_REM: begin
                n_rem   = r_last - quo_prod[VW-1:0];
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // step the estimate up until the remainder is below the divisor
                if (rem_ge) begin
                    n_rem = r_rem - DIV_STEP;
                    n_quo = r_quo + QW'(1);
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                n_state = ST_SWAP;
            end
            ST_SWAP: begin
                if (swap_go) begin
                    ram_we = 1'b1;
                    n_last = ram_rd;
                    if (r_discard) begin
                        n_discard = 1'b0;
                        n_state   = ST_CHECK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_seed    <= VW'(1);
            r_lehmer  <= '0;
            r_last    <= '0;
            r_cnt     <= '0;
            r_seeding <= 1'b0;
            r_discard <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_lehmer  <= n_lehmer;
            r_last    <= n_last;
            r_cnt     <= n_cnt;
            r_seeding <= n_seeding;
            r_discard <= n_discard;
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
        end
    end

    // table index datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= ram_rd;
            r_out_near  <= (ram_rd >= spmr_pkg::NEAR_ONE_LIMIT);
        end
    end

    assign s_axis_tready   = (r_state == ST_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {1'b0, r_out_value};
    assign m_axis_tuser[0] = r_out_near;

endmodule

// ----- rtl/spmr_ram.sv -----
// ----------------------------------------------------------------------------
// spmr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module spmr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/spmr_lehmer_unit.sv -----
// ----------------------------------------------------------------------------
// spmr_lehmer_unit
// one lehmer step x' = 16807 * x mod (2^31-1):
// registered multiply, then fold of the high bits and one conditional subtract
// ----------------------------------------------------------------------------
module spmr_lehmer_unit (
    input  logic              i_clk,
    input  logic              i_load,
    input  spmr_pkg::t_value  i_x,
    output spmr_pkg::t_value  o_next
);

    localparam int VW = spmr_pkg::VALUE_W;
    localparam int PW = spmr_pkg::PROD_W;

    logic [PW-1:0] r_prod;
    logic [VW:0]   fold_sum;
    logic [VW:0]   fold_sub;

    // product register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PW'(i_x) * PW'(spmr_pkg::LEHMER_MUL);
        end
    end

    // 2^31 == 1 mod (2^31-1): add the high part onto the low part
    assign fold_sum = (VW+1)'(r_prod[PW-1:VW]) + (VW+1)'(r_prod[VW-1:0]);
    assign fold_sub = fold_sum - {1'b0, spmr_pkg::LEHMER_MOD};
    assign o_next   = (fold_sum >= {1'b0, spmr_pkg::LEHMER_MOD}) ? fold_sub[VW-1:0]
                                                                 : fold_sum[VW-1:0];

endmodule

// ----- rtl/spmr_checker.sv -----
// ----------------------------------------------------------------------------
// spmr_checker
// port-level checks of the generator, bound to the top level
// ----------------------------------------------------------------------------
`include "shuffled_park_miller_rng_assert.svh"

module spmr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] i_m_tdata,
    input logic [0:0]  i_m_tuser
);

    // a stalled result stays offered
    `SPMR_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)

    // the block is busy right after taking a request
    `SPMR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready)

    // the flag follows the value
    `SPMR_ASSERT_NOW(a_near_one_flag, i_clk, i_rst_n, i_m_tvalid, i_m_tuser[0] == (i_m_tdata[30:0] >= spmr_pkg::NEAR_ONE_LIMIT))

    // a result is a nonzero residue and the pad bit is clear
    `SPMR_ASSERT_NOW(a_value_range, i_clk, i_rst_n, i_m_tvalid, i_m_tdata[30:0] != 31'd0 && i_m_tdata[30:0] != spmr_pkg::LEHMER_MOD && !i_m_tdata[31])

endmodule

bind shuffled_park_miller_rng spmr_checker u_spmr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
